FILE: hdl/ialu_pkg.sv
package ialu_pkg;

   // operation codes
   localparam logic [3:0] OP_NOP     = 4'd0;
   localparam logic [3:0] OP_ADD     = 4'd1;
   localparam logic [3:0] OP_PASSB   = 4'd2;
   localparam logic [3:0] OP_SUB     = 4'd3;
   localparam logic [3:0] OP_AND     = 4'd4;
   localparam logic [3:0] OP_OR      = 4'd5;
   localparam logic [3:0] OP_XOR     = 4'd6;
   localparam logic [3:0] OP_ANDN    = 4'd7;
   localparam logic [3:0] OP_XNOR    = 4'd8;
   localparam logic [3:0] OP_ORN     = 4'd9;
   localparam logic [3:0] OP_SLL     = 4'd10;
   localparam logic [3:0] OP_SRL     = 4'd11;
   localparam logic [3:0] OP_SRA     = 4'd12;
   localparam logic [3:0] OP_SETHI   = 4'd13;
   localparam logic [3:0] OP_MULSTEP = 4'd14;

   localparam int XLEN      = 32;
   localparam int SHW       = 5;
   localparam int IMM_W     = 22;
   localparam int SETHI_POS = 10;

   // which unit produces the result in the second stage
   typedef enum logic [1:0] {
      SEL_LOGIC = 2'd0,
      SEL_ADDER = 2'd1,
      SEL_SHIFT = 2'd2
   } sel_type;

   // how V and C are formed
   typedef enum logic [1:0] {
      RULE_NONE = 2'd0,
      RULE_ADD  = 2'd1,
      RULE_SUB  = 2'd2
   } rule_type;

   typedef enum logic [1:0] {
      SHIFT_LL = 2'd0,
      SHIFT_RL = 2'd1,
      SHIFT_RA = 2'd2
   } shift_type;

   typedef struct packed {
      logic              thread_active;
      logic [3:0]        operation;
      logic [XLEN-1:0]   operand_a;
      logic [XLEN-1:0]   operand_b;
      logic              use_carry;
      logic              signed_multiply;
      logic [IMM_W-1:0]  immediate_22;
      logic              write_flags;
      logic              carry_in;
      logic              negative_in;
      logic              overflow_in;
      logic [XLEN-1:0]   y_in;
   } req_type;

   typedef struct packed {
      logic              executed;
      logic [XLEN-1:0]   result;
      logic [3:0]        flags;
      logic              flags_valid;
      logic [XLEN-1:0]   y_out;
   } rsp_type;

   // decoded item after the first stage
   typedef struct packed {
      logic              active;
      logic              wf;
      rule_type          rule;
      sel_type           sel;
      shift_type         shift_op;
      logic [SHW-1:0]    sh;
      logic [XLEN-1:0]   x;
      logic [XLEN-1:0]   y;
      logic              cin;
      logic              fa31;
      logic              fb31;
      logic [XLEN-1:0]   logic_res;
      logic [XLEN-1:0]   yo;
   } s1_type;

   // computed item after the second stage
   typedef struct packed {
      logic              active;
      logic              wf;
      rule_type          rule;
      logic              fa31;
      logic              fb31;
      logic [XLEN-1:0]   result;
      logic [XLEN-1:0]   yo;
   } s2_type;

endpackage

FILE: hdl/ialu_decode.sv
module ialu_decode
   import ialu_pkg::*;
(
   input  req_type req,
   output s1_type  dec
);

   logic [XLEN-1:0] a;
   logic [XLEN-1:0] b;
   logic [XLEN-1:0] sa;
   logic [XLEN-1:0] addend;

   assign a      = req.operand_a;
   assign b      = req.operand_b;
   // multiply step: shifted a with N^V on top, addend gated by Y[0]
   assign sa     = {req.negative_in ^ req.overflow_in, a[XLEN-1:1]};
   assign addend = req.y_in[0] ? b : '0;

   // operand setup, logic ops and result routing
   always_comb begin
      dec           = '0;
      dec.active    = req.thread_active;
      dec.wf        = req.write_flags;
      dec.rule      = RULE_NONE;
      dec.sel       = SEL_LOGIC;
      dec.shift_op  = SHIFT_LL;
      dec.sh        = b[SHW-1:0];
      dec.x         = a;
      dec.y         = b;
      dec.cin       = 1'b0;
      dec.fa31      = a[XLEN-1];
      dec.fb31      = b[XLEN-1];
      dec.logic_res = '0;
      dec.yo        = req.y_in;
      unique case (req.operation)
         OP_ADD: begin
            dec.sel  = SEL_ADDER;
            dec.rule = RULE_ADD;
            dec.cin  = req.use_carry & req.carry_in;
         end
         OP_SUB: begin
            // a - b - c as a + ~b + (1 - c)
            dec.sel  = SEL_ADDER;
            dec.rule = RULE_SUB;
            dec.y    = ~b;
            dec.cin  = req.use_carry ? ~req.carry_in : 1'b1;
         end
         OP_PASSB: dec.logic_res = b;
         OP_AND:   dec.logic_res = a & b;
         OP_OR:    dec.logic_res = a | b;
         OP_XOR:   dec.logic_res = a ^ b;
         OP_ANDN:  dec.logic_res = a & ~b;
         OP_XNOR:  dec.logic_res = ~(a ^ b);
         OP_ORN:   dec.logic_res = a | ~b;
         OP_SLL: begin
            dec.sel      = SEL_SHIFT;
            dec.shift_op = SHIFT_LL;
         end
         OP_SRL: begin
            dec.sel      = SEL_SHIFT;
            dec.shift_op = SHIFT_RL;
         end
         OP_SRA: begin
            dec.sel      = SEL_SHIFT;
            dec.shift_op = SHIFT_RA;
         end
         OP_SETHI: dec.logic_res = {req.immediate_22, {SETHI_POS{1'b0}}};
         OP_MULSTEP: begin
            dec.rule = RULE_ADD;
            if (req.signed_multiply) begin
               dec.sel  = SEL_ADDER;
               dec.x    = sa;
               dec.y    = addend;
               dec.fa31 = sa[XLEN-1];
               dec.fb31 = addend[XLEN-1];
               // an inactive thread keeps its Y
               dec.yo   = req.thread_active ? {a[0], req.y_in[XLEN-1:1]} : req.y_in;
            end
         end
         default: dec.logic_res = '0;
      endcase
   end

endmodule

FILE: hdl/ialu_flags.sv
module ialu_flags
   import ialu_pkg::*;
(
   input  s2_type  s2,
   output rsp_type rsp
);

   logic r31;
   logic zero;
   logic v;
   logic c;

   assign r31  = s2.result[XLEN-1];
   assign zero = (s2.result == '0);

   // V and C from the operand and result sign bits
   always_comb begin
      v = 1'b0;
      c = 1'b0;
      unique case (s2.rule)
         RULE_ADD: begin
            v = (s2.fa31 == s2.fb31) && (s2.fa31 != r31);
            c = (s2.fa31 && s2.fb31) || (!r31 && (s2.fa31 || s2.fb31));
         end
         RULE_SUB: begin
            v = (s2.fa31 != s2.fb31) && (s2.fa31 != r31);
            c = (!s2.fa31 && s2.fb31) || ((!s2.fa31 || s2.fb31) && r31);
         end
         default: begin
            v = 1'b0;
            c = 1'b0;
         end
      endcase
   end

   // inactive thread passes only Y through
   always_comb begin
      rsp       = '0;
      rsp.y_out = s2.yo;
      if (s2.active) begin
         rsp.executed    = 1'b1;
         rsp.result      = s2.result;
         rsp.flags_valid = s2.wf;
         rsp.flags       = s2.wf ? {r31, zero, v, c} : 4'd0;
      end
   end

endmodule

FILE: hdl/integer_alu_with_condition_flags_unit.sv
// An accepted item moves through the decode and add/shift registers into the output register.
// Throughput: one item per cycle unless rsp_stall holds it; each stage holds one item.
// Each stage advances when its successor is empty or moving, so bubbles collapse under stall.
// Reset (synchronous, active high) clears the stage valid bits; payload is not reset.
module integer_alu_with_condition_flags_unit
   import ialu_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_item,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_item
);

   s1_type  dec_in;
   s1_type  s1_ff;
   logic    s1_valid_ff;
   s2_type  s2_in;
   s2_type  s2_ff;
   logic    s2_valid_ff;
   rsp_type rsp_in;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   logic            ready1;
   logic            ready2;
   logic            ready3;
   logic [XLEN-1:0] sum;
   logic [XLEN-1:0] shifted;

   // per-stage ready chain from the output back
   assign ready3    = !rsp_valid_ff || !rsp_stall;
   assign ready2    = !s2_valid_ff || ready3;
   assign ready1    = !s1_valid_ff || ready2;
   assign req_stall = !ready1;

   // stage 1: decode and operand setup
   ialu_decode u_decode (
      .req (req_item),
      .dec (dec_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (ready1) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && req_valid) begin
         s1_ff <= dec_in;
      end
   end

   // stage 2: adder and barrel shifter
   assign sum = s1_ff.x + s1_ff.y + {{(XLEN-1){1'b0}}, s1_ff.cin};

   always_comb begin
      unique case (s1_ff.shift_op)
         SHIFT_RL: shifted = s1_ff.x >> s1_ff.sh;
         SHIFT_RA: shifted = $unsigned($signed(s1_ff.x) >>> s1_ff.sh);
         default:  shifted = s1_ff.x << s1_ff.sh;
      endcase
   end

   always_comb begin
      s2_in.active = s1_ff.active;
      s2_in.wf     = s1_ff.wf;
      s2_in.rule   = s1_ff.rule;
      s2_in.fa31   = s1_ff.fa31;
      s2_in.fb31   = s1_ff.fb31;
      s2_in.yo     = s1_ff.yo;
      unique case (s1_ff.sel)
         SEL_ADDER: s2_in.result = sum;
         SEL_SHIFT: s2_in.result = shifted;
         default:   s2_in.result = s1_ff.logic_res;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (ready2) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready2 && s1_valid_ff) begin
         s2_ff <= s2_in;
      end
   end

   // stage 3: flags and output register
   ialu_flags u_flags (
      .s2  (s2_ff),
      .rsp (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ready3) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ready3 && s2_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // a blocked middle stage keeps its item
   a_s2_hold: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !ready3 |=> s2_valid_ff && $stable(s2_ff))
      else $error("stage 2 item lost or changed under stall");

   // a blocked first stage keeps its item
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !ready2 |=> s1_valid_ff && $stable(s1_ff))
      else $error("stage 1 item lost or changed under stall");

   // a stalled input means every stage is occupied
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff && s2_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled with a free stage");

   // inactive thread gives no result and no flags
   a_inactive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_item.executed |->
         rsp_item.result == '0 && rsp_item.flags == 4'd0 && !rsp_item.flags_valid)
      else $error("inactive thread produced result or flags");

endmodule
